### rtl/bdbf_pkg.sv
// Shared types and constants for the block-decaying Bloom filter.
// No dependencies.
package bdbf_pkg;

  localparam int unsigned DEF_CELL_COUNT = 4096;
  localparam int unsigned DEF_CELL_BITS  = 16;
  localparam int unsigned DEF_NUM_HASHES = 8;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned WRAP_W  = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned BASE_W  = 15;
  localparam int unsigned COUNT_W = 15;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Register addresses (byte address / 4)
  localparam logic [1:0] REG_WRAP   = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  // Classified operation passed from front to back
  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_CLEAR = 2'd1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                last;
    logic                insert;
    logic [INDEX_W-1:0]  index;
  } work_t;

endpackage

### rtl/bdbf_front.sv
// Front end: accepts input transfers, drops command three, classifies the rest
// and pushes them into a two-entry queue. Depends on bdbf_pkg.
module bdbf_front import bdbf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [INDEX_W-1:0] cell_index,
  input  logic               last_index,
  output logic               q_valid,
  input  logic               q_pop,
  output work_t              q_head
);

  work_t      q_mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push;
  work_t      item;

  assign ready = (fill != 2'd2);
  assign push  = valid && ready && (cmd != CMD_NONE);
  assign q_valid = (fill != 2'd0);
  assign q_head  = q_mem[rd_ptr];

  // classify the incoming transfer
  always_comb begin
    item.op     = (cmd == CMD_CLEAR) ? OP_CLEAR : OP_CHECK;
    item.last   = last_index;
    item.insert = (cmd == CMD_INSERT);
    item.index  = cell_index;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= item;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### rtl/bdbf_back.sv
// Back end: cell memory, check, insert write-back, decay and clear sweeps,
// and a one-entry result register. Depends on bdbf_pkg.
module bdbf_back import bdbf_pkg::*; #(
  parameter int unsigned CELL_COUNT = DEF_CELL_COUNT,
  parameter int unsigned CELL_BITS  = DEF_CELL_BITS,
  parameter int unsigned NUM_HASHES = DEF_NUM_HASHES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  work_t               q_head,
  input  logic [WRAP_W-1:0]   counter_wrap,
  input  logic [PERIOD_W-1:0] advance_period,
  input  logic [BASE_W-1:0]   insert_base,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                duplicate
);

  localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned PW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam int unsigned PCW = $clog2(NUM_HASHES + 1);
  localparam int unsigned VW = (CELL_BITS > 17) ? CELL_BITS : 17;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_WRITE, S_DECAY_RD, S_DECAY_WR, S_CLEAR, S_MOD
  } state_t;

  state_t state;
  logic [CELL_BITS-1:0] cells [CELL_COUNT];
  logic [CELL_BITS-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CELL_BITS-1:0] wr_data;

  logic [AW-1:0]  pend [NUM_HASHES];
  logic [PCW-1:0] pend_cnt;
  logic [PW-1:0]  wr_idx;
  logic           miss_seen;
  logic [COUNT_W-1:0]  running_count;
  logic [PERIOD_W-1:0] period_phase;
  logic [AW-1:0]  sweep;
  logic [CELL_BITS-1:0] ins_val;
  work_t          cur;

  logic [WRAP_W-1:0]   eff_wrap;
  logic [COUNT_W:0]    rc_inc;
  logic [PERIOD_W:0]   ph_inc;
  logic [VW-1:0]       val_wide;
  logic [CELL_BITS-1:0] cell_max;

  // serial remainder of the advanced counter by the wrap
  logic [WRAP_W-1:0]   mod_rem;
  logic [COUNT_W:0]    mod_num;
  logic [3:0]          mod_cnt;
  logic [WRAP_W:0]     mod_trial;
  logic [WRAP_W:0]     mod_next;

  // effective wrap, clamped to 2..32768
  always_comb begin
    if (counter_wrap < WRAP_W'(2)) eff_wrap = WRAP_W'(2);
    else if (counter_wrap > WRAP_W'(32768)) eff_wrap = WRAP_W'(32768);
    else eff_wrap = counter_wrap;
  end

  assign rc_inc   = {1'b0, running_count} + (COUNT_W+1)'(1);
  assign ph_inc   = {1'b0, period_phase} + (PERIOD_W+1)'(1);
  assign cell_max = '1;

  // one restoring step of the remainder
  assign mod_trial = {mod_rem, mod_num[COUNT_W]};
  assign mod_next  = (mod_trial >= {1'b0, eff_wrap}) ?
                     mod_trial - {1'b0, eff_wrap} : mod_trial;

  // cell memory
  always_ff @(posedge clk) begin
    if (wr_en) cells[wr_addr] <= wr_data;
    rd_data <= cells[rd_addr];
  end

  assign q_pop = (state == S_IDLE) && q_valid &&
                 !(q_head.op == OP_CHECK && q_head.last && out_valid);

  // memory port steering
  always_comb begin
    rd_addr = q_head.index[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pend[wr_idx];
    wr_data = ins_val;
    case (state)
      S_DECAY_RD, S_DECAY_WR: rd_addr = sweep;
      default: ;
    endcase
    case (state)
      S_WRITE: wr_en = 1'b1;
      S_DECAY_WR: begin
        wr_en   = 1'b1;
        wr_addr = sweep;
        wr_data = (VW'(rd_data) <= VW'(eff_wrap)) ?
                  '0 : rd_data - CELL_BITS'(eff_wrap);
      end
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep;
        wr_data = '0;
      end
      default: ;
    endcase
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sweep         <= '0;
      pend_cnt      <= '0;
      miss_seen     <= 1'b0;
      running_count <= '0;
      period_phase  <= '0;
      out_valid     <= 1'b0;
      wr_idx        <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_head;
            if (q_head.op == OP_CLEAR) begin
              sweep     <= '0;
              pend_cnt  <= '0;
              miss_seen <= 1'b0;
              state     <= S_CLEAR;
            end else begin
              if (pend_cnt < PCW'(NUM_HASHES)) begin
                pend[pend_cnt[PW-1:0]] <= q_head.index[AW-1:0];
                pend_cnt <= pend_cnt + PCW'(1);
              end
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (VW'(rd_data) < VW'(running_count) || miss_seen) begin
            miss_seen <= 1'b1;
          end
          if (cur.last) begin
            out_valid <= 1'b1;
            duplicate <= !(miss_seen || VW'(rd_data) < VW'(running_count));
            miss_seen <= 1'b0;
            if (cur.insert) begin
              // advance running counter and phase
              if (period_phase == '0) begin
                if (rc_inc < (COUNT_W+1)'(eff_wrap)) running_count <= rc_inc[COUNT_W-1:0];
                else running_count <= '0;
              end
              if (ph_inc >= (PERIOD_W+1)'(advance_period)) period_phase <= '0;
              else period_phase <= ph_inc[PERIOD_W-1:0];
              wr_idx <= '0;
              sweep  <= '0;
              if (period_phase == '0 && rc_inc > (COUNT_W+1)'(eff_wrap)) begin
                // counter left above a lowered wrap: take the remainder
                mod_num <= rc_inc;
                mod_rem <= '0;
                mod_cnt <= '0;
                state   <= S_MOD;
              end else if (period_phase == '0 && rc_inc == (COUNT_W+1)'(eff_wrap))
                state <= S_DECAY_RD;
              else
                state <= S_READ;
            end else begin
              pend_cnt <= '0;
              state    <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_MOD: begin
          mod_rem <= mod_next[WRAP_W-1:0];
          mod_num <= {mod_num[COUNT_W-1:0], 1'b0};
          mod_cnt <= mod_cnt + 4'd1;
          if (mod_cnt == 4'(COUNT_W)) begin
            running_count <= mod_next[COUNT_W-1:0];
            if (mod_next == '0) state <= S_DECAY_RD;
            else state <= S_READ;
          end
        end
        S_READ: begin
          // latch the insert value for the write-back
          if (val_wide > VW'(cell_max)) ins_val <= cell_max;
          else ins_val <= val_wide[CELL_BITS-1:0];
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (PCW'(wr_idx) + PCW'(1) >= pend_cnt) begin
            pend_cnt <= '0;
            state    <= S_IDLE;
          end else begin
            wr_idx <= wr_idx + PW'(1);
          end
        end
        S_DECAY_RD: state <= S_DECAY_WR;
        S_DECAY_WR: begin
          if (sweep == AW'(CELL_COUNT - 1)) state <= S_READ;
          else begin
            sweep <= sweep + AW'(1);
            state <= S_DECAY_RD;
          end
        end
        S_CLEAR: begin
          if (sweep == AW'(CELL_COUNT - 1)) state <= S_IDLE;
          sweep <= sweep + AW'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign val_wide = VW'(insert_base) + VW'(running_count) + VW'(1);

endmodule

### rtl/block_decaying_bloom_filter_core.sv
// Top level of the block-decaying Bloom filter: APB registers, front end
// and back end. Depends on bdbf_pkg, bdbf_front, bdbf_back.
//
//  channel | signals                         | direction
//  input   | valid/ready, cmd, cell_index,   | in
//          | last_index                      |
//  output  | out_valid/out_ready, duplicate  | out
//  config  | APB psel..pready                | in/out
//
// A hash index passes a memory read and a check; the last index of an insert
// adds a state that latches the insert value, then a write-back per stored
// index. A counter left above a lowered wrap adds a serial remainder step. A
// counter wrap adds a decay sweep that reads and writes every cell; a clear
// zeroes every cell. After reset a clearing pass runs before any index is
// processed; transfers are queued (two entries) meanwhile. A stalled result
// holds the back end only when the next element's last index is reached.
module block_decaying_bloom_filter_core import bdbf_pkg::*; #(
  parameter int unsigned CELL_COUNT = DEF_CELL_COUNT,
  parameter int unsigned CELL_BITS  = DEF_CELL_BITS,
  parameter int unsigned NUM_HASHES = DEF_NUM_HASHES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               valid,
  output logic               ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [INDEX_W-1:0] cell_index,
  input  logic               last_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               duplicate
);

  logic [WRAP_W-1:0]   counter_wrap;
  logic [PERIOD_W-1:0] advance_period;
  logic [BASE_W-1:0]   insert_base;
  logic   q_valid, q_pop;
  work_t  q_head;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_wrap   <= WRAP_W'(128);
      advance_period <= PERIOD_W'(1);
      insert_base    <= BASE_W'(64);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WRAP:   counter_wrap   <= pwdata[WRAP_W-1:0];
        REG_PERIOD: advance_period <= pwdata[PERIOD_W-1:0];
        REG_BASE:   insert_base    <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[3:2])
      REG_WRAP:   prdata = {16'd0, counter_wrap};
      REG_PERIOD: prdata = {16'd0, advance_period};
      REG_BASE:   prdata = {17'd0, insert_base};
      default:    prdata = '0;
    endcase
  end

  bdbf_front u_front (
    .clk, .rst, .valid, .ready, .cmd, .cell_index, .last_index,
    .q_valid, .q_pop, .q_head
  );

  bdbf_back #(
    .CELL_COUNT(CELL_COUNT), .CELL_BITS(CELL_BITS), .NUM_HASHES(NUM_HASHES)
  ) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head,
    .counter_wrap, .advance_period, .insert_base,
    .out_valid, .out_ready, .duplicate
  );

  // a pop needs something queued
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // a pending result is never overwritten before transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result lost");

  // stalled result keeps its value
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(duplicate)) else $error("result changed");

endmodule

### sim/tb.sv
// Self-checking testbench for block_decaying_bloom_filter_core.
// Depends on bdbf_pkg and the core RTL; holds its own filter predictor.
module tb;
  import bdbf_pkg::*;

  localparam int NCELLS   = 4096;
  localparam int NHASH    = 8;
  localparam int CELL_MAX = 65535;
  localparam int STALL_LIMIT = 40000;

  // Scoreboard: predicts duplicate flags and checks results in order
  class dup_scoreboard;
    int unsigned cells[NCELLS];
    int unsigned run_count, phase;
    int unsigned held_idx[NHASH];
    int unsigned held_n;
    bit miss;
    int unsigned wrap_reg, period_reg, base_reg;
    bit dup_q[$];
    int errors;

    function void reset_state();
      foreach (cells[i]) cells[i] = 0;
      run_count = 0; phase = 0; held_n = 0; miss = 0;
      wrap_reg = 128; period_reg = 1; base_reg = 64;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] addr, logic [31:0] data);
      case (addr)
        REG_WRAP:   wrap_reg = data[15:0];
        REG_PERIOD: period_reg = data[15:0];
        REG_BASE:   base_reg = data[14:0];
        default: ;
      endcase
    endfunction

    // Commit an insert: counter advance, optional decay, write-back
    function void commit_insert();
      int unsigned w, v;
      w = (wrap_reg < 2) ? 2 : (wrap_reg > 32768) ? 32768 : wrap_reg;
      if (phase == 0) begin
        run_count = (run_count + 1) % w;
        if (run_count == 0)
          foreach (cells[i]) cells[i] = (cells[i] <= w) ? 0 : cells[i] - w;
      end
      phase++;
      if (phase >= period_reg) phase = 0;
      v = base_reg + run_count + 1;
      if (v > CELL_MAX) v = CELL_MAX;
      for (int i = 0; i < held_n; i++) cells[held_idx[i]] = v;
    endfunction

    function void note_input(cmd_t c, logic [11:0] idx, logic lst);
      if (c == CMD_CLEAR) begin
        foreach (cells[i]) cells[i] = 0;
        held_n = 0; miss = 0;
        return;
      end
      if (c == CMD_NONE) return;
      if (cells[idx] < run_count) miss = 1;
      if (held_n < NHASH) begin
        held_idx[held_n] = idx; held_n++;
      end
      if (!lst) return;
      dup_q.push_back(!miss);
      if (c == CMD_INSERT) commit_insert();
      held_n = 0; miss = 0;
    endfunction

    function void check_result(logic dup);
      bit want;
      if (dup_q.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      want = dup_q.pop_front();
      if (dup !== want)
        report_mismatch($sformatf("duplicate got %0b want %0b", dup, want));
    endfunction

    function void report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic valid = 0, ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [INDEX_W-1:0] cell_index = '0;
  logic last_index = 0;
  logic out_valid, out_ready = 0, duplicate;

  dup_scoreboard sb;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit want_gaps = 1;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  block_decaying_bloom_filter_core DUT (.*);

  // Sample transfers on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (valid && ready) sb.note_input(cmd_t'(cmd), cell_index, last_index);
      if (out_valid && out_ready) sb.check_result(duplicate);
      if ((valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: long stretch with no transfer on either channel
  always @(posedge clk) begin
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 70) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 0;
      else if (want_gaps && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  task automatic apb_write(logic [1:0] reg_id, logic [31:0] data);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_id, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(reg_id, data);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid drops only over a gap, so back-to-back transfers see one update
  task automatic send_item(cmd_t c, logic [11:0] idx, logic lst);
    int g;
    g = want_gaps ? gap_len() : 0;
    if (g > 0) begin
      valid <= 0;
      repeat (g) @(posedge clk);
    end
    valid <= 1; cmd <= c; cell_index <= idx; last_index <= lst;
    do @(posedge clk); while (!ready);
  endtask

  // One element of n hash indices drawn from the range 0..pool
  task automatic send_element(cmd_t c, int n, int pool);
    for (int i = 0; i < n; i++)
      send_item((i == n - 1) ? c : cmd_t'($urandom_range(0, 1)),
                12'($urandom_range(0, pool)), i == n - 1);
  endtask

  task automatic drain();
    int t;
    t = 0;
    valid <= 0;
    while (sb.dup_q.size() != 0 && t < 200000) begin
      @(posedge clk); t++;
    end
    repeat (2 * NCELLS + 200) @(posedge clk);
  endtask

  task automatic random_phase(int n_elems, int pool);
    int r;
    for (int e = 0; e < n_elems; e++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_element(CMD_INSERT, int'($urandom_range(1, 10)), pool);
      else if (r < 90) send_element(CMD_LOOKUP, int'($urandom_range(1, 10)), pool);
      else if (r < 93) send_item(CMD_CLEAR, 12'($urandom), 1'($urandom));
      else if (r < 96) send_item(CMD_NONE, 12'($urandom), 1'($urandom));
      else send_item(cmd_t'($urandom_range(0, 1)), 12'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: field extremes, every command, overflow of indices
    send_element(CMD_INSERT, 1, 0);
    send_item(CMD_LOOKUP, 12'd0, 1);
    send_item(CMD_INSERT, 12'hFFF, 1);
    send_item(CMD_LOOKUP, 12'hFFF, 1);
    send_item(CMD_INSERT, 12'h555, 0);
    send_item(CMD_LOOKUP, 12'hAAA, 1);
    send_item(CMD_NONE, 12'hFFF, 1);
    send_item(CMD_LOOKUP, 12'd7, 0);
    send_item(CMD_CLEAR, 12'hFFF, 1);
    for (int i = 0; i < 10; i++) send_item(CMD_INSERT, 12'(i * 400), i == 9);
    for (int i = 0; i < 10; i++) send_item(CMD_LOOKUP, 12'(i * 400), i == 9);
    drain();

    // Small wrap: frequent decay sweeps
    apb_write(REG_WRAP, 32'd2);
    apb_write(REG_PERIOD, 32'd1);
    apb_write(REG_BASE, 32'd0);
    random_phase(40, 31);
    drain();

    // Out-of-range and extreme settings
    apb_write(REG_WRAP, 32'd0);
    apb_write(REG_PERIOD, 32'd0);
    apb_write(REG_BASE, 32'h7FFF);
    random_phase(30, 63);
    drain();
    apb_write(REG_WRAP, 32'hFFFF);
    apb_write(REG_PERIOD, 32'hFFFF);
    random_phase(30, 4095);
    drain();

    // Mid-range: long hold-off on the result side while items keep coming
    apb_write(REG_WRAP, 32'd8);
    apb_write(REG_PERIOD, 32'd3);
    apb_write(REG_BASE, 32'd5);
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20, 15);
    join
    drain();

    // Bulk random, a sender pause until every result is in, then a gapless burst
    apb_write(REG_WRAP, 32'd16);
    apb_write(REG_PERIOD, 32'd2);
    apb_write(REG_BASE, 32'd3);
    random_phase(220, 127);
    drain();
    want_gaps = 0;
    random_phase(40, 63);
    want_gaps = 1;
    drain();

    if (sb.errors == 0 && sb.dup_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
